// ----- rtl/mcg_pkg.sv -----
// Shared constants and codes for the midpoint circle generator.
package mcg_pkg;

  localparam int MCG_COORD_BITS   = 12;
  localparam int MCG_QUEUE_DEPTH  = 2;
  localparam int MCG_PIX_PER_STEP = 8;
  localparam int MCG_IDX_W        = $clog2(MCG_PIX_PER_STEP);

  // request kinds on the input channel
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // job kinds between front and back
  localparam logic JOB_EMPTY  = 1'b0;
  localparam logic JOB_PIXELS = 1'b1;

endpackage

// ----- rtl/mcg_front.sv -----
// Front end: accepts requests, advances the midpoint state and queues pixel or empty jobs.
module mcg_front import mcg_pkg::*; #(
  parameter int COORD_BITS = MCG_COORD_BITS,
  localparam int RAD_W = COORD_BITS - 1,
  localparam int DEC_W = COORD_BITS + 2,
  localparam int JOB_W = 2 + 2 * COORD_BITS + 2 * RAD_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] req_cx,
  input  logic [COORD_BITS-1:0] req_cy,
  input  logic [RAD_W-1:0]      req_radius,
  output logic                  job_push,
  output logic [JOB_W-1:0]      job_data,
  input  logic                  job_full
);

  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [RAD_W-1:0]      sx_r, sx_nxt;
  logic [RAD_W-1:0]      sy_r, sy_nxt;
  logic [DEC_W-1:0]      dec_r, dec_nxt;
  logic                  active_r, active_nxt;

  logic [RAD_W-1:0]      adv_x, adv_y;
  logic [DEC_W-1:0]      adv_dec;
  logic                  job_kind, job_done;
  logic                  accept;

  assign req_ready = !job_full;
  assign accept    = req_valid && req_ready;
  assign job_push  = accept;

  always_comb begin
    adv_x = sx_r + RAD_W'(1);
    if (dec_r[DEC_W-1]) begin
      adv_y   = sy_r;
      adv_dec = dec_r + {2'b00, adv_x, 1'b1};
    end else begin
      adv_y   = sy_r - RAD_W'(1);
      adv_dec = dec_r + {2'b00, adv_x, 1'b1} - {2'b00, adv_y, 1'b0};
    end
  end

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    job_kind   = JOB_PIXELS;
    job_done   = 1'b1;
    if (req_type == REQ_START) begin
      cx_nxt     = req_cx;
      cy_nxt     = req_cy;
      sx_nxt     = '0;
      sy_nxt     = req_radius;
      dec_nxt    = DEC_W'(1) - {3'b000, req_radius};
      active_nxt = (req_radius != '0);
      job_done   = (req_radius == '0);
    end else if (!active_r) begin
      // no circle in progress: one empty word, state untouched
      job_kind = JOB_EMPTY;
    end else begin
      sx_nxt     = adv_x;
      sy_nxt     = adv_y;
      dec_nxt    = adv_dec;
      active_nxt = adv_x < adv_y;
      job_done   = !(adv_x < adv_y);
    end
  end

  assign job_data = {job_kind, job_done, cx_nxt, cy_nxt, sx_nxt, sy_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      sx_r     <= '0;
      sy_r     <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      sx_r     <= sx_nxt;
      sy_r     <= sy_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ----- rtl/mcg_queue.sv -----
// Short job queue between the front end and the pixel emitter.
module mcg_queue import mcg_pkg::*; #(
  parameter int WIDTH = 48,
  parameter int DEPTH = MCG_QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/mcg_back.sv -----
// Back end: 8 symmetric pixels a job (empty: one word), one a cycle if ready.
module mcg_back import mcg_pkg::*; #(
  parameter int COORD_BITS = MCG_COORD_BITS,
  localparam int RAD_W = COORD_BITS - 1,
  localparam int PIX_W = COORD_BITS + 2,
  localparam int JOB_W = 2 + 2 * COORD_BITS + 2 * RAD_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_avail,
  input  logic [JOB_W-1:0]        job_data,
  output logic                    job_pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic signed [PIX_W-1:0] res_px,
  output logic signed [PIX_W-1:0] res_py,
  output logic                    res_pvalid,
  output logic                    res_last,
  output logic                    res_done
);

  logic [JOB_W-1:0]     job_r;
  logic                 job_valid_r, job_valid_nxt;
  logic [MCG_IDX_W-1:0] idx_r, idx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]     px_r, py_r;
  logic                 pv_r, last_r, done_r;

  logic [RAD_W-1:0]      jx, jy, u, v;
  logic [COORD_BITS-1:0] jcx, jcy;
  logic                  jkind, jdone;
  logic [PIX_W-1:0]      ue, ve, px_calc, py_calc;
  logic                  emit, last_now;

  assign jy    = job_r[RAD_W-1:0];
  assign jx    = job_r[2*RAD_W-1:RAD_W];
  assign jcy   = job_r[2*RAD_W+COORD_BITS-1:2*RAD_W];
  assign jcx   = job_r[2*RAD_W+2*COORD_BITS-1:2*RAD_W+COORD_BITS];
  assign jdone = job_r[JOB_W-2];
  assign jkind = job_r[JOB_W-1];

  // second half of the octants swaps the roles of x and y
  assign u  = idx_r[2] ? jy : jx;
  assign v  = idx_r[2] ? jx : jy;
  assign ue = {3'b000, u};
  assign ve = {3'b000, v};
  assign px_calc = {2'b00, jcx} + (idx_r[0] ? -ue : ue);
  assign py_calc = {2'b00, jcy} + (idx_r[1] ? -ve : ve);

  assign emit     = job_valid_r && (!out_valid_r || res_ready);
  assign last_now = (jkind == JOB_EMPTY) || (idx_r == MCG_IDX_W'(MCG_PIX_PER_STEP - 1));
  assign job_pop  = job_avail && (!job_valid_r || (emit && last_now));

  always_comb begin
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    if (job_pop) begin
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit) begin
      if (last_now) begin
        job_valid_nxt = 1'b0;
      end
      idx_nxt = idx_r + MCG_IDX_W'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_data;
    end
    if (emit) begin
      if (jkind == JOB_EMPTY) begin
        px_r <= '0;
        py_r <= '0;
        pv_r <= 1'b0;
      end else begin
        px_r <= px_calc;
        py_r <= py_calc;
        pv_r <= 1'b1;
      end
      last_r <= last_now;
      done_r <= jdone;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_px     = px_r;
  assign res_py     = py_r;
  assign res_pvalid = pv_r;
  assign res_last   = last_r;
  assign res_done   = done_r;

endmodule

// ----- rtl/midpoint_circle_generator.sv -----
// Top level of the midpoint circle rasteriser.
//
//  channel | direction | tdata                               | tuser                        | tlast
//  in_     | slave     | center_x, center_y, radius          | req_type                     | -
//  out_    | master    | pixel_x, pixel_y                    | pixel_valid, circle_done     | last_of_step
//
// A start or advance word produces eight pixel words, one per cycle while out_tready
// holds, and the pixel emitter is the bottleneck. An advance with no circle in
// progress produces one empty word. The front end takes a request every cycle while
// the two-entry job queue has room, so stalls on out_ only back up into in_tready
// once the queue fills. Reset is synchronous; no clearing pass is needed.
module midpoint_circle_generator import mcg_pkg::*; #(
  parameter int COORD_BITS = MCG_COORD_BITS,
  localparam int RAD_W      = COORD_BITS - 1,
  localparam int PIX_W      = COORD_BITS + 2,
  localparam int IN_DATA_W  = ((3 * COORD_BITS - 1 + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((2 * PIX_W + 7) / 8) * 8,
  localparam int JOB_W      = 2 + 2 * COORD_BITS + 2 * RAD_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // center_x, center_y, radius, zero pad
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic [1:0]            out_tuser,  // pixel_valid, circle_done
  output logic                  out_tlast   // last_of_step
);

  logic                    q_push, q_full, q_pop, q_avail;
  logic [JOB_W-1:0]        q_in, q_out;
  logic signed [PIX_W-1:0] px, py;
  logic                    pvalid, done;

  mcg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_type   (in_tuser),
    .req_cx     (in_tdata[COORD_BITS-1:0]),
    .req_cy     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .req_radius (in_tdata[2*COORD_BITS+RAD_W-1:2*COORD_BITS]),
    .job_push   (q_push),
    .job_data   (q_in),
    .job_full   (q_full)
  );

  mcg_queue #(.WIDTH(JOB_W), .DEPTH(MCG_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_avail)
  );

  mcg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (q_avail),
    .job_data   (q_out),
    .job_pop    (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_px     (px),
    .res_py     (py),
    .res_pvalid (pvalid),
    .res_last   (out_tlast),
    .res_done   (done)
  );

  assign out_tdata = OUT_DATA_W'({py, px});
  assign out_tuser = {done, pvalid};

endmodule

// ----- dv/midpoint_circle_generator_test.sv -----
// Self-checking testbench for the midpoint circle generator: directed table, random circles.
module midpoint_circle_generator_test import mcg_pkg::*;;

  localparam int IN_W       = 40;
  localparam int OUT_W      = 32;
  localparam int RAND_ITEMS = 400;
  localparam int DRAIN_WAIT = 16;
  localparam int CYCLE_CAP  = 300000;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic [13:0] px;
    logic [13:0] py;
    logic        valid;
    logic        last;
    logic        done;
  } pixel_word_t;

  typedef struct {
    logic        req;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [10:0] r;
    bit          typed;
    logic [13:0] tpx;
    logic [13:0] tpy;
    logic        tvalid;
    logic        tdone;
    int          tcount;
  } req_item_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;   // center_x, center_y, radius, zero pad
  logic            in_tuser;   // req_type
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata; // pixel_x, pixel_y, zero pad
  logic [1:0]      out_tuser;  // pixel_valid, circle_done
  logic            out_tlast;  // last_of_step

  // rasteriser state as the predictor sees it
  logic [11:0]        ctr_col;
  logic [11:0]        ctr_row;
  logic [10:0]        pos_x;
  logic [10:0]        pos_y;
  logic signed [13:0] dec_term;
  logic               in_progress;

  pixel_word_t step_words[$];
  pixel_word_t pixel_q[$];
  req_item_t   accept_q[$];
  req_item_t   dir_tab[$];

  bit no_gaps;
  int n_sent, n_starts, n_words, n_empty, n_errors, n_cycles;

  midpoint_circle_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d words outstanding", n_cycles, pixel_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 31);
  end

  function automatic req_item_t row(logic req, int cx, int cy, int r, bit typed = 0,
                                    int tpx = 0, int tpy = 0, logic tv = 0,
                                    logic td = 0, int tn = 0);
    req_item_t it;
    it.req    = req;
    it.cx     = 12'(cx);
    it.cy     = 12'(cy);
    it.r      = 11'(r);
    it.typed  = typed;
    it.tpx    = 14'(tpx);
    it.tpy    = 14'(tpy);
    it.tvalid = tv;
    it.tdone  = td;
    it.tcount = tn;
    return it;
  endfunction

  // number of advance steps a fresh circle of radius r takes to finish
  function automatic int steps_to_finish(int r);
    int x, y, p, n;
    x = 0;
    y = r;
    p = 1 - r;
    n = 0;
    while (x < y) begin
      x++;
      if (p < 0) begin
        p = p + 2 * x + 1;
      end else begin
        y--;
        p = p + 2 * (x - y) + 1;
      end
      n++;
    end
    return n;
  endfunction

  task automatic add_word(int px, int py, bit last);
    step_words.push_back('{px: 14'(px), py: 14'(py), valid: 1'b1, last: last,
                           done: !in_progress});
  endtask

  task automatic push_octants();
    int cx, cy, x, y;
    cx = int'(ctr_col);
    cy = int'(ctr_row);
    x  = int'(pos_x);
    y  = int'(pos_y);
    in_progress = (x < y);
    add_word(cx + x, cy + y, 0);
    add_word(cx - x, cy + y, 0);
    add_word(cx + x, cy - y, 0);
    add_word(cx - x, cy - y, 0);
    add_word(cx + y, cy + x, 0);
    add_word(cx - y, cy + x, 0);
    add_word(cx + y, cy - x, 0);
    add_word(cx - y, cy - x, 1);
  endtask

  task automatic predict_request(req_item_t it);
    int x, y, p;
    step_words.delete();
    if (it.req == REQ_START) begin
      ctr_col  = it.cx;
      ctr_row  = it.cy;
      pos_x    = '0;
      pos_y    = it.r;
      dec_term = 14'(1 - int'(it.r));
      push_octants();
    end else if (!in_progress) begin
      step_words.push_back('{px: '0, py: '0, valid: 1'b0, last: 1'b1, done: 1'b1});
    end else begin
      p = int'(dec_term);
      x = int'(11'(pos_x + 11'd1));
      y = int'(pos_y);
      if (p < 0) begin
        p = p + 2 * x + 1;
      end else begin
        y = int'(11'(pos_y - 11'd1));
        p = p + 2 * (x - y) + 1;
      end
      pos_x    = 11'(x);
      pos_y    = 11'(y);
      dec_term = 14'(p);
      push_octants();
    end
  endtask

  task automatic take_request(req_item_t it);
    predict_request(it);
    if (it.req == REQ_START) n_starts++;
    if (it.typed) begin
      for (int k = 0; k < it.tcount; k++)
        pixel_q.push_back('{px: it.tpx, py: it.tpy, valid: it.tvalid,
                            last: (k == it.tcount - 1), done: it.tdone});
    end else begin
      foreach (step_words[k]) pixel_q.push_back(step_words[k]);
    end
  endtask

  task automatic check_word();
    pixel_word_t exp_w, got_w;
    got_w = '{px: out_tdata[13:0], py: out_tdata[27:14], valid: out_tuser[0],
              last: out_tlast, done: out_tuser[1]};
    n_words++;
    if (!got_w.valid) n_empty++;
    if (pixel_q.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_SHOWN)
        $display("Unexpected word: x=%0d y=%0d valid=%b last=%b done=%b",
                 $signed(got_w.px), $signed(got_w.py), got_w.valid, got_w.last, got_w.done);
      return;
    end
    exp_w = pixel_q.pop_front();
    if (got_w.px !== exp_w.px || got_w.py !== exp_w.py || got_w.valid !== exp_w.valid ||
        got_w.last !== exp_w.last || got_w.done !== exp_w.done) begin
      n_errors++;
      if (n_errors <= MAX_SHOWN) begin
        $display("Mismatch at word %0d: exp x=%0d y=%0d v=%b l=%b d=%b",
                 n_words, $signed(exp_w.px), $signed(exp_w.py), exp_w.valid, exp_w.last,
                 exp_w.done);
        $display("  got x=%0d y=%0d v=%b l=%b d=%b",
                 $signed(got_w.px), $signed(got_w.py), got_w.valid, got_w.last,
                 got_w.done);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    req_item_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it = accept_q.pop_front();
        take_request(it);
      end
      if (out_tvalid && out_tready) check_word();
    end
  end

  // hold the word until accepted; valid is only dropped when a gap follows
  task automatic offer(req_item_t it);
    if (!no_gaps) begin
      while ($urandom_range(99) < 31) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    accept_q.push_back(it);
    in_tvalid <= 1'b1;
    in_tuser  <= it.req;
    in_tdata  <= {5'b0, it.r, it.cy, it.cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  initial begin : stimulus
    int n_rand, gen_left, k, rad;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_START;
    no_gaps     = 1'b0;
    ctr_col     = '0;
    ctr_row     = '0;
    pos_x       = '0;
    pos_y       = '0;
    dec_term    = '0;
    in_progress = 1'b0;

    // advance with nothing in progress, extreme centres and radii, abandon, full run
    dir_tab.push_back(row(REQ_ADVANCE, 123, 456, 7, 1, 0, 0, 0, 1, 1));
    dir_tab.push_back(row(REQ_START, 4095, 4095, 0, 1, 4095, 4095, 1, 1, 8));
    dir_tab.push_back(row(REQ_ADVANCE, 4095, 0, 2047, 1, 0, 0, 0, 1, 1));
    dir_tab.push_back(row(REQ_START, 0, 0, 0, 1, 0, 0, 1, 1, 8));
    dir_tab.push_back(row(REQ_START, 0, 0, 2047));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0));
    dir_tab.push_back(row(REQ_ADVANCE, 4095, 4095, 2047));
    dir_tab.push_back(row(REQ_START, 4095, 4095, 2047));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0));
    dir_tab.push_back(row(REQ_START, 2048, 2048, 1));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0, 1, 0, 0, 0, 1, 1));
    dir_tab.push_back(row(REQ_START, 1000, 3000, 3));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0));
    dir_tab.push_back(row(REQ_START, 100, 200, 5));
    dir_tab.push_back(row(REQ_ADVANCE, 1, 2, 3));
    dir_tab.push_back(row(REQ_ADVANCE, 4, 5, 6));
    dir_tab.push_back(row(REQ_ADVANCE, 7, 8, 9));
    dir_tab.push_back(row(REQ_ADVANCE, 10, 11, 12));
    dir_tab.push_back(row(REQ_ADVANCE, 0, 0, 0, 1, 0, 0, 0, 1, 1));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) offer(dir_tab[i]);

    // mostly whole circles, some abandoned early, some stray advances
    n_rand   = 0;
    gen_left = 0;
    while (n_rand < RAND_ITEMS) begin
      if ($urandom_range(99) < 8) begin
        offer(row(REQ_ADVANCE, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(2047)));
        n_rand++;
        if (gen_left > 0) gen_left--;
      end else begin
        k = $urandom_range(99);
        if (k < 70)      rad = $urandom_range(24);
        else if (k < 90) rad = $urandom_range(200, 25);
        else             rad = $urandom_range(2047);
        offer(row(REQ_START, $urandom_range(4095), $urandom_range(4095), rad));
        n_rand++;
        gen_left = steps_to_finish(rad);
        k = gen_left + int'($urandom_range(3) == 0);
        if ($urandom_range(99) < 15) k = $urandom_range(gen_left);
        if (k > 60) k = $urandom_range(60, 20);
        repeat (k) begin
          offer(row(REQ_ADVANCE, $urandom_range(4095), $urandom_range(4095),
                    $urandom_range(2047)));
          n_rand++;
          if (gen_left > 0) gen_left--;
        end
      end
      no_gaps = (n_rand >= 150 && n_rand < 250);
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    n_errors += pixel_q.size();

    $display("Drove %0d requests including %0d circle starts;", n_sent, n_starts);
    $display("checked %0d output words, %0d without a pixel, %0d mismatches.",
             n_words, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
